[rtl/core/olist_pkg.sv]
package olist_pkg;

    // Default sizes
    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the transaction payloads
    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Index and count width on the cell control bus, wide enough for the
    // largest supported capacity (0..256)
    localparam int CTL_IDX_W = 9;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE_AT   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REMOVE_VAL  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FIND        = 3'd6;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // Cell operations
    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_INSERT     = 2'd1;
    localparam logic [1:0] CELL_REMOVE     = 2'd2;
    localparam logic [1:0] CELL_REMOVE_HIT = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic                     found;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
    } t_rsp;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic [1:0]           op;
        logic [CTL_IDX_W-1:0] idx;
        logic [CTL_IDX_W-1:0] count;
        logic [WORD_W-1:0]    value;
    } t_cell_ctl;

endpackage

[rtl/core/olist_cell.sv]
module olist_cell #(
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  logic                   i_clk,
    input  olist_pkg::t_cell_ctl   i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_left_data,
    input  logic [VALUE_WIDTH-1:0] i_right_data,
    input  logic                   i_hit_before,
    output logic                   o_hit_through,
    output logic [VALUE_WIDTH-1:0] o_data
);

    localparam int IW = olist_pkg::CTL_IDX_W;
    localparam int WW = olist_pkg::WORD_W;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic [VALUE_WIDTH-1:0] n_data;
    logic [VALUE_WIDTH-1:0] cmd_value;
    logic                   match;

    // Fit the command word to the stored width
    generate
        if (VALUE_WIDTH > WW) begin : g_wide
            assign cmd_value = {{(VALUE_WIDTH-WW){1'b0}}, i_ctl.value};
        end else begin : g_narrow
            assign cmd_value = i_ctl.value[VALUE_WIDTH-1:0];
        end
    endgenerate

    // Compare against the command word, only while this slot is occupied
    assign match         = (r_data == cmd_value) && (MY_IDX < i_ctl.count);
    assign o_hit_through = i_hit_before | match;

    // Hold, load, or take a neighbor's word
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            olist_pkg::CELL_INSERT: begin
                if (MY_IDX == i_ctl.idx) begin
                    n_data = cmd_value;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_data = i_left_data;
                end
            end
            olist_pkg::CELL_REMOVE: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_data = i_right_data;
                end
            end
            olist_pkg::CELL_REMOVE_HIT: begin
                if (o_hit_through) begin
                    n_data = i_right_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/core/ordered_list_engine.sv]
// Each accepted command's result is registered. Throughput: one command per cycle
// unless the output stalls; every cell shifts or loads in the same cycle, and the
// search hit ripples through the chain of cells within that cycle.
// Reset: synchronous, active low; clears the entry count and the result valid.
// List words are not cleared and need no clearing pass; unused slots are never read.
module ordered_list_engine #(
    parameter int CAPACITY    = olist_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  olist_pkg::t_cmd i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output olist_pkg::t_rsp o_out_data
);

    localparam int IW    = olist_pkg::CTL_IDX_W;
    localparam int WW    = olist_pkg::WORD_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic                         r_out_valid;
    logic [olist_pkg::STAT_W-1:0] r_status;
    logic [olist_pkg::STAT_W-1:0] n_status;
    logic                         r_found;
    logic                         n_found;

    logic                         in_accept;
    logic [1:0]                   cmd_op;
    logic [IW-1:0]                cmd_idx;
    logic [IW-1:0]                cnt_x;
    logic [IW-1:0]                pos_x;
    logic                         is_full;
    logic                         hit_any;
    olist_pkg::t_cell_ctl         cell_ctl;

    logic [VALUE_WIDTH-1:0]       cell_data [CAPACITY];
    logic [CAPACITY:0]            hit_chain;
    logic [CNT_W-1:0]             back_idx;
    logic [VALUE_WIDTH-1:0]       front_raw;
    logic [VALUE_WIDTH-1:0]       back_raw;
    logic [WW-1:0]                front_word;
    logic [WW-1:0]                back_word;
    logic                         list_empty;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    assign cnt_x   = IW'(r_count);
    assign pos_x   = IW'(i_in_data.position);
    assign is_full = (cnt_x >= IW'(CAPACITY));
    assign hit_any = hit_chain[CAPACITY];

    // Decode the command against the current count and search hit
    always_comb begin
        cmd_op   = olist_pkg::CELL_HOLD;
        cmd_idx  = '0;
        n_status = olist_pkg::ST_IGNORED;
        n_found  = 1'b0;
        n_count  = r_count;
        case (i_in_data.mode)
            olist_pkg::MODE_PUSH_FRONT, olist_pkg::MODE_PUSH_BACK: begin
                if (is_full) begin
                    n_status = olist_pkg::ST_FULL;
                end else begin
                    cmd_op   = olist_pkg::CELL_INSERT;
                    cmd_idx  = (i_in_data.mode == olist_pkg::MODE_PUSH_FRONT) ? '0 : cnt_x;
                    n_status = olist_pkg::ST_DONE;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            olist_pkg::MODE_POP_FRONT: begin
                if (cnt_x != '0) begin
                    cmd_op   = olist_pkg::CELL_REMOVE;
                    n_status = olist_pkg::ST_DONE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            olist_pkg::MODE_INSERT: begin
                if (pos_x <= cnt_x) begin
                    if (is_full) begin
                        n_status = olist_pkg::ST_FULL;
                    end else begin
                        cmd_op   = olist_pkg::CELL_INSERT;
                        cmd_idx  = pos_x;
                        n_status = olist_pkg::ST_DONE;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
            end
            olist_pkg::MODE_REMOVE_AT: begin
                if (pos_x != '0 && pos_x <= cnt_x) begin
                    cmd_op   = olist_pkg::CELL_REMOVE;
                    cmd_idx  = pos_x - IW'(1);
                    n_status = olist_pkg::ST_DONE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            olist_pkg::MODE_REMOVE_VAL: begin
                if (hit_any) begin
                    cmd_op   = olist_pkg::CELL_REMOVE_HIT;
                    n_status = olist_pkg::ST_DONE;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            olist_pkg::MODE_FIND: begin
                if (hit_any) begin
                    n_found  = 1'b1;
                    n_status = olist_pkg::ST_DONE;
                end
            end
            default: begin
                n_status = olist_pkg::ST_IGNORED;
            end
        endcase
    end

    // Broadcast to the chain; cells only move on an accepted transaction
    always_comb begin
        cell_ctl.op    = in_accept ? cmd_op : olist_pkg::CELL_HOLD;
        cell_ctl.idx   = cmd_idx;
        cell_ctl.count = cnt_x;
        cell_ctl.value = i_in_data.value;
    end

    assign hit_chain[0] = 1'b0;

    // Chain of cells, one list slot each
    generate
        for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [VALUE_WIDTH-1:0] left_data;
            logic [VALUE_WIDTH-1:0] right_data;

            if (gi == 0) begin : g_first
                assign left_data = '0;
            end else begin : g_mid_l
                assign left_data = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_data = '0;
            end else begin : g_mid_r
                assign right_data = cell_data[gi+1];
            end

            olist_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .CELL_INDEX  (gi)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (cell_ctl),
                .i_left_data   (left_data),
                .i_right_data  (right_data),
                .i_hit_before  (hit_chain[gi]),
                .o_hit_through (hit_chain[gi+1]),
                .o_data        (cell_data[gi])
            );
        end
    endgenerate

    // Count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    // Read the ends of the list; they hold until the next transaction
    assign list_empty = (r_count == '0);
    assign back_idx   = r_count - CNT_W'(1);
    assign front_raw  = cell_data[0];
    assign back_raw   = cell_data[back_idx[IDX_W-1:0]];

    generate
        if (VALUE_WIDTH >= WW) begin : g_out_wide
            assign front_word = front_raw[WW-1:0];
            assign back_word  = back_raw[WW-1:0];
        end else begin : g_out_narrow
            assign front_word = {{(WW-VALUE_WIDTH){1'b0}}, front_raw};
            assign back_word  = {{(WW-VALUE_WIDTH){1'b0}}, back_raw};
        end
    endgenerate

    always_comb begin
        o_out_data.status      = r_status;
        o_out_data.found       = r_found;
        o_out_data.count       = olist_pkg::COUNT_W'(r_count);
        o_out_data.is_empty    = list_empty;
        o_out_data.front_value = list_empty ? '0 : front_word;
        o_out_data.back_value  = list_empty ? '0 : back_word;
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_stable: assert property (@(posedge i_clk)
        (i_rst_n && !in_accept) |=> $stable(r_count))
        else $error("entry count moved without a transaction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction gave no result");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == olist_pkg::ST_FULL) |-> r_count == CNT_W'(CAPACITY))
        else $error("full reported on a list with room");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> r_status == olist_pkg::ST_DONE)
        else $error("found set with a status other than done");

endmodule

[bench/ordered_list_engine_test.sv]
module ordered_list_engine_test;

    localparam int CAP = olist_pkg::CAPACITY_DEF;
    localparam logic [olist_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int RAND_ITEMS  = 1100;
    localparam int PHASE_LEN   = 80;
    localparam int HOLD_AT     = 250;
    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_FROM  = 500;
    localparam int QUIET_TO    = 700;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        olist_pkg::t_cmd cmd;
        bit              has_lit;
        olist_pkg::t_rsp lit;
    } t_dir_row;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            cmd_valid = 1'b0;
    olist_pkg::t_cmd cmd_data  = '0;
    logic            rsp_ready = 1'b0;
    logic            cmd_ready;
    logic            rsp_valid;
    olist_pkg::t_rsp rsp_data;

    // Model state and expected results
    logic signed [olist_pkg::WORD_W-1:0] list_words [$];
    olist_pkg::t_rsp                     expected_rsp [$];
    t_dir_row                            dir_tbl [$];

    int mismatches   = 0;
    int rsp_checked  = 0;
    int full_seen    = 0;
    int ignored_seen = 0;
    int peak_depth   = 0;
    int sent_cnt     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    wire quiet_stretch = (sent_cnt >= QUIET_FROM) && (sent_cnt < QUIET_TO);

    ordered_list_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in_data   (cmd_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Apply one command to the list and return the result it produces
    function automatic olist_pkg::t_rsp update_list(input olist_pkg::t_cmd c);
        olist_pkg::t_rsp r;
        int   n;
        int   hit;
        int   i;
        r = '0;
        r.status = olist_pkg::ST_IGNORED;
        n = list_words.size();
        hit = -1;
        for (i = 0; i < n; i++) begin
            if (hit < 0 && list_words[i] == c.value) hit = i;
        end
        case (c.mode)
            olist_pkg::MODE_PUSH_FRONT, olist_pkg::MODE_PUSH_BACK: begin
                if (n >= CAP) begin
                    r.status = olist_pkg::ST_FULL;
                end else begin
                    if (c.mode == olist_pkg::MODE_PUSH_FRONT) list_words.insert(0, c.value);
                    else list_words.insert(n, c.value);
                    r.status = olist_pkg::ST_DONE;
                end
            end
            olist_pkg::MODE_POP_FRONT: begin
                if (n > 0) begin
                    list_words.delete(0);
                    r.status = olist_pkg::ST_DONE;
                end
            end
            olist_pkg::MODE_INSERT: begin
                if (int'(c.position) <= n) begin
                    if (n >= CAP) begin
                        r.status = olist_pkg::ST_FULL;
                    end else begin
                        list_words.insert(int'(c.position), c.value);
                        r.status = olist_pkg::ST_DONE;
                    end
                end
            end
            olist_pkg::MODE_REMOVE_AT: begin
                if (c.position >= 1 && int'(c.position) <= n) begin
                    list_words.delete(int'(c.position) - 1);
                    r.status = olist_pkg::ST_DONE;
                end
            end
            olist_pkg::MODE_REMOVE_VAL: begin
                if (hit >= 0) begin
                    list_words.delete(hit);
                    r.status = olist_pkg::ST_DONE;
                end
            end
            olist_pkg::MODE_FIND: begin
                if (hit >= 0) begin
                    r.found  = 1'b1;
                    r.status = olist_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
        n = list_words.size();
        r.count    = olist_pkg::COUNT_W'(n);
        r.is_empty = (n == 0);
        if (n > 0) begin
            r.front_value = list_words[0];
            r.back_value  = list_words[n-1];
        end
        return r;
    endfunction

    // Random command; grow phases favor pushes, shrink phases favor removals
    function automatic olist_pkg::t_cmd gen_list_cmd(input bit grow);
        olist_pkg::t_cmd c;
        int   n;
        int   r;
        int   rv;
        c = '0;
        n = list_words.size();
        r = $urandom_range(99);
        if (r < 2) c.mode = MODE_UNUSED;
        else if (r < 14) c.mode = olist_pkg::MODE_FIND;
        else if (r < 24) c.mode = olist_pkg::MODE_REMOVE_VAL;
        else if (grow ? (r < 70) : (r < 44)) begin
            case ($urandom_range(2))
                0: c.mode = olist_pkg::MODE_PUSH_FRONT;
                1: c.mode = olist_pkg::MODE_PUSH_BACK;
                default: c.mode = olist_pkg::MODE_INSERT;
            endcase
        end else begin
            c.mode = $urandom_range(1) ? olist_pkg::MODE_POP_FRONT : olist_pkg::MODE_REMOVE_AT;
        end
        if ($urandom_range(99) < 85) c.position = olist_pkg::POS_W'($urandom_range(n + 1));
        else c.position = olist_pkg::POS_W'($urandom_range(31));
        rv = $urandom_range(99);
        if (n > 0 && rv < 45) begin
            c.value = list_words[$urandom_range(n - 1)];
        end else if (rv < 55) begin
            case ($urandom_range(3))
                0: c.value = 32'sh7FFF_FFFF;
                1: c.value = 32'sh8000_0000;
                2: c.value = '0;
                default: c.value = -32'sd1;
            endcase
        end else begin
            c.value = $urandom();
        end
        return c;
    endfunction

    function automatic t_dir_row plain_row(input logic [olist_pkg::MODE_W-1:0] m, input int p,
                                           input logic [olist_pkg::WORD_W-1:0] v);
        t_dir_row d;
        d.cmd.mode     = m;
        d.cmd.position = olist_pkg::POS_W'(p);
        d.cmd.value    = v;
        d.has_lit      = 1'b0;
        d.lit          = '0;
        return d;
    endfunction

    function automatic t_dir_row lit_row(input logic [olist_pkg::MODE_W-1:0] m, input int p,
                                         input logic [olist_pkg::WORD_W-1:0] v,
                                         input logic [olist_pkg::STAT_W-1:0] st,
                                         input int cnt,
                                         input logic [olist_pkg::WORD_W-1:0] fv,
                                         input logic [olist_pkg::WORD_W-1:0] bv);
        t_dir_row d;
        d = plain_row(m, p, v);
        d.has_lit         = 1'b1;
        d.lit.status      = st;
        d.lit.found       = 1'b0;
        d.lit.count       = olist_pkg::COUNT_W'(cnt);
        d.lit.is_empty    = (cnt == 0);
        d.lit.front_value = fv;
        d.lit.back_value  = bv;
        return d;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input t_dir_row d);
        dir_tbl.insert(dir_tbl.size(), d);
    endfunction

    // Offer one transaction, hold it until accepted, then record its result
    task automatic send_cmd(input olist_pkg::t_cmd c, input bit has_lit,
                            input olist_pkg::t_rsp lit);
        olist_pkg::t_rsp pred;
        while (!quiet_stretch && $urandom_range(99) < 31) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do @(posedge clk); while (!cmd_ready);
        pred = update_list(c);
        if (pred.status == olist_pkg::ST_FULL) full_seen++;
        if (pred.status == olist_pkg::ST_IGNORED) ignored_seen++;
        if (list_words.size() > peak_depth) peak_depth = list_words.size();
        expected_rsp.insert(expected_rsp.size(), has_lit ? lit : pred);
        sent_cnt <= sent_cnt + 1;
    endtask

    task automatic check_field(input string name, input logic [olist_pkg::WORD_W-1:0] expv,
                               input logic [olist_pkg::WORD_W-1:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0h, actual %0h", name, expv, actv);
            mismatches++;
        end
    endtask

    // Compare each result against the oldest expectation
    always @(posedge clk) begin
        olist_pkg::t_rsp e;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
                $error("result with no expectation: status %0d count %0d",
                       rsp_data.status, rsp_data.count);
                mismatches++;
            end else begin
                e = expected_rsp[0];
                expected_rsp.delete(0);
                check_field("status", e.status, rsp_data.status);
                check_field("found", e.found, rsp_data.found);
                check_field("count", e.count, rsp_data.count);
                check_field("is_empty", e.is_empty, rsp_data.is_empty);
                check_field("front_value", e.front_value, rsp_data.front_value);
                check_field("back_value", e.back_value, rsp_data.back_value);
                rsp_checked++;
            end
        end
    end

    // Receiver: random stalls, one long hold-off, one stretch with no stalls
    always @(posedge clk) begin
        if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_cnt >= HOLD_AT) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (quiet_stretch) begin
            rsp_ready <= 1'b1;
        end else begin
            rsp_ready <= ($urandom_range(99) >= 31);
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge clk) begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int k;
        logic [olist_pkg::MODE_W-1:0] fill_mode;

        // Empty list: every removal, lookup, out-of-range insert and unused mode is ignored
        add_row(lit_row(olist_pkg::MODE_POP_FRONT, 0, 32'd0, olist_pkg::ST_IGNORED, 0, 0, 0));
        add_row(lit_row(olist_pkg::MODE_REMOVE_VAL, 0, 32'd5, olist_pkg::ST_IGNORED, 0, 0, 0));
        add_row(lit_row(olist_pkg::MODE_FIND, 0, 32'd0, olist_pkg::ST_IGNORED, 0, 0, 0));
        add_row(lit_row(olist_pkg::MODE_REMOVE_AT, 0, 32'd0, olist_pkg::ST_IGNORED, 0, 0, 0));
        add_row(lit_row(olist_pkg::MODE_INSERT, 1, 32'd9, olist_pkg::ST_IGNORED, 0, 0, 0));
        add_row(lit_row(MODE_UNUSED, 31, 32'hFFFF_FFFF, olist_pkg::ST_IGNORED, 0, 0, 0));
        // Extreme words at both ends, then inserts, removals and a lookup
        add_row(lit_row(olist_pkg::MODE_PUSH_FRONT, 0, 32'h7FFF_FFFF, olist_pkg::ST_DONE, 1,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_row(lit_row(olist_pkg::MODE_PUSH_BACK, 0, 32'h8000_0000, olist_pkg::ST_DONE, 2,
                        32'h7FFF_FFFF, 32'h8000_0000));
        add_row(plain_row(olist_pkg::MODE_INSERT, 1, 32'hFFFF_FFFF));
        add_row(plain_row(olist_pkg::MODE_INSERT, 3, 32'h5555_5555));
        add_row(plain_row(olist_pkg::MODE_REMOVE_AT, 4, 32'd0));
        add_row(plain_row(olist_pkg::MODE_REMOVE_AT, 5, 32'd0));
        add_row(plain_row(olist_pkg::MODE_REMOVE_VAL, 0, 32'h7FFF_FFFF));
        add_row(plain_row(olist_pkg::MODE_FIND, 0, 32'd12345));
        // Fill to capacity
        for (k = 0; k < CAP - 2; k++) begin
            fill_mode = (k % 3 == 0) ? olist_pkg::MODE_PUSH_FRONT :
                        (k % 3 == 1) ? olist_pkg::MODE_PUSH_BACK : olist_pkg::MODE_INSERT;
            add_row(plain_row(fill_mode, k / 2, 32'h1357_9BDF * (k + 1)));
        end
        // Full list: growth refused, range check ahead of full check; then a lookup and removals
        add_row(plain_row(olist_pkg::MODE_PUSH_BACK, 0, 32'hAAAA_AAAA));
        add_row(plain_row(olist_pkg::MODE_INSERT, CAP, 32'h0F0F_0F0F));
        add_row(plain_row(olist_pkg::MODE_INSERT, CAP + 1, 32'hF0F0_F0F0));
        add_row(plain_row(olist_pkg::MODE_PUSH_FRONT, 0, 32'h0000_0001));
        add_row(plain_row(olist_pkg::MODE_FIND, 0, 32'hFFFF_FFFF));
        add_row(plain_row(olist_pkg::MODE_REMOVE_AT, CAP, 32'd0));
        add_row(plain_row(olist_pkg::MODE_REMOVE_VAL, 0, 32'h8000_0000));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_tbl.size(); k++)
            send_cmd(dir_tbl[k].cmd, dir_tbl[k].has_lit, dir_tbl[k].lit);
        for (k = 0; k < RAND_ITEMS; k++)
            send_cmd(gen_list_cmd((k / PHASE_LEN) % 2 == 0), 1'b0, '0);
        cmd_valid <= 1'b0;

        // Drain outstanding results
        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d commands: %0d full, %0d ignored",
                 rsp_checked, dir_tbl.size() + RAND_ITEMS, full_seen, ignored_seen);
        $display("list depth peaked at %0d of %0d entries", peak_depth, CAP);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
